FILE: rtl/gct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gct_pkg
// Shared types and codes for the glyph class table lookup unit.
// ----------------------------------------------------------------------------
package gct_pkg;

   localparam int DEF_MAX_ENTRIES = 256;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_FORMAT      = 2'd0;
   localparam logic [1:0] REG_FIRST_GLYPH = 2'd1;
   localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;

   localparam logic [1:0] FMT_ARRAY = 2'd1;
   localparam logic [1:0] FMT_RANGE = 2'd2;

   typedef enum logic [1:0] {
      FN_LOAD_ARRAY = 2'd0,
      FN_LOAD_RANGE = 2'd1,
      FN_CLASS_OF   = 2'd2,
      FN_HAS_CLASS  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MM_ARRAY_CLASS = 2'd0,
      MM_RANGE_GLYPH = 2'd1,
      MM_ARRAY_HAS   = 2'd2,
      MM_RANGE_HAS   = 2'd3
   } match_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] cls;
   } span_rec_type;

   typedef struct packed {
      logic [1:0]  table_format;
      logic [15:0] first_glyph;
      logic [8:0]  entry_count;
   } csr_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] cls;
   } match_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] class_out;
      logic        found;
   } result_type;

endpackage

FILE: rtl/glyph_class_table_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_class_table_lookup_unit
// Font class-definition table engine: dense class array or glyph range
// records, loaded by request, queried for the class of a glyph or for the
// presence of a class among the entries in use.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_stall     func slot glyph span_first
//                                                   span_last class_in
//   rsp_      out         rsp_valid / rsp_stall     class_out found
//   csr_      in/out      psel penable pwrite pready paddr pwdata prdata
//
// Loads write the table at accept and go straight to the done state; a format-1
// class query makes one fetch inside the array, none outside; formats 0 and 3
// answer zero with no fetch. Range lookups and has-class scans read one entry
// per cycle through the shared compare unit and stop at the first hit.
// Reset (synchronous, high) clears CSRs, result valid and sequencer, not the memories.
// req_stall is high while a request is in work; a held result only delays the
// finish of the next request.
//
// CSR map (byte address): 0x0 table_format, 0x4 first_glyph, 0x8 entry_count.
// ----------------------------------------------------------------------------
module glyph_class_table_lookup_unit
   import gct_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   localparam int AW = $clog2(MAX_ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_func,
   input  logic [7:0]            req_slot,
   input  logic [15:0]           req_glyph,
   input  logic [15:0]           req_span_first,
   input  logic [15:0]           req_span_last,
   input  logic [15:0]           req_class_in,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_class_out,
   output logic                  rsp_found,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [1:0]  table_format_ff;
   logic [15:0] first_glyph_ff;
   logic [8:0]  entry_count_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   csr_type     csr;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_class_ff, rsp_class_in;
   logic        rsp_found_ff, rsp_found_in;
   logic        out_free;

   // internal links
   result_type     res;
   match_type      match;
   match_mode_type mode;
   logic [15:0]    glyph_q;
   logic [15:0]    class_q;
   logic           class_wr_en;
   logic           range_wr_en;
   logic [AW-1:0]  wr_addr;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [15:0]    rd_class;
   span_rec_type   rd_rec;
   span_rec_type   wr_rec;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         table_format_ff <= 2'd0;
         first_glyph_ff  <= 16'd0;
         entry_count_ff  <= 9'd0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FORMAT:      table_format_ff <= csr_pwdata[1:0];
            REG_FIRST_GLYPH: first_glyph_ff  <= csr_pwdata[15:0];
            REG_ENTRY_COUNT: entry_count_ff  <= csr_pwdata[8:0];
            default: ;  // unmapped slot, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FORMAT:      csr_prdata = {30'd0, table_format_ff};
         REG_FIRST_GLYPH: csr_prdata = {16'd0, first_glyph_ff};
         REG_ENTRY_COUNT: csr_prdata = {23'd0, entry_count_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign csr.table_format = table_format_ff;
   assign csr.first_glyph  = first_glyph_ff;
   assign csr.entry_count  = entry_count_ff;

   assign wr_rec.lo  = req_span_first;
   assign wr_rec.hi  = req_span_last;
   assign wr_rec.cls = req_class_in;

   gct_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_slot     (req_slot),
      .req_glyph    (req_glyph),
      .req_class_in (req_class_in),
      .out_free     (out_free),
      .res          (res),
      .class_wr_en  (class_wr_en),
      .range_wr_en  (range_wr_en),
      .wr_addr      (wr_addr),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .mode         (mode),
      .glyph_q      (glyph_q),
      .class_q      (class_q),
      .match        (match)
   );

   gct_store #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_store (
      .clock       (clock),
      .class_wr_en (class_wr_en),
      .range_wr_en (range_wr_en),
      .wr_addr     (wr_addr),
      .wr_class    (req_class_in),
      .wr_rec      (wr_rec),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_class    (rd_class),
      .rd_rec      (rd_rec)
   );

   gct_match u_match (
      .mode     (mode),
      .glyph    (glyph_q),
      .class_in (class_q),
      .rd_class (rd_class),
      .rd_rec   (rd_rec),
      .result   (match)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;
      rsp_found_in = rsp_found_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = res.class_out;
         rsp_found_in = res.found;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_ff <= rsp_class_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_class_out = rsp_class_ff;
   assign rsp_found     = rsp_found_ff;

endmodule

FILE: rtl/gct_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gct_store
// Class array and range record memories, one registered read port shared.
// ----------------------------------------------------------------------------
module gct_store
   import gct_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   localparam int AW = $clog2(MAX_ENTRIES)
) (
   input  logic              clock,
   input  logic              class_wr_en,
   input  logic              range_wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [15:0]       wr_class,
   input  span_rec_type      wr_rec,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [15:0]       rd_class,
   output span_rec_type      rd_rec
);

   logic [15:0]  class_mem_ff [MAX_ENTRIES];
   span_rec_type range_mem_ff [MAX_ENTRIES];
   logic [15:0]  class_rd_ff;
   span_rec_type rec_rd_ff;

   always_ff @(posedge clock) begin
      if (class_wr_en) begin
         class_mem_ff[wr_addr] <= wr_class;
      end
      if (range_wr_en) begin
         range_mem_ff[wr_addr] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         class_rd_ff <= class_mem_ff[rd_addr];
         rec_rd_ff   <= range_mem_ff[rd_addr];
      end
   end

   assign rd_class = class_rd_ff;
   assign rd_rec   = rec_rd_ff;

endmodule

FILE: rtl/gct_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gct_match
// Shared compare unit: tests one fetched entry against the current query.
// ----------------------------------------------------------------------------
module gct_match
   import gct_pkg::*;
(
   input  match_mode_type mode,
   input  logic [15:0]    glyph,
   input  logic [15:0]    class_in,
   input  logic [15:0]    rd_class,
   input  span_rec_type   rd_rec,
   output match_type      result
);

   always_comb begin
      result.hit = 1'b0;
      result.cls = 16'd0;
      unique case (mode)
         MM_ARRAY_CLASS: begin
            result.hit = 1'b1;
            result.cls = rd_class;
         end
         MM_RANGE_GLYPH: begin
            // empty span (lo above hi) never matches
            result.hit = (glyph >= rd_rec.lo) && (glyph <= rd_rec.hi);
            result.cls = rd_rec.cls;
         end
         MM_ARRAY_HAS: begin
            result.hit = (rd_class == class_in);
         end
         MM_RANGE_HAS: begin
            result.hit = (rd_rec.cls == class_in);
         end
         default: begin
            result.hit = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/gct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gct_ctrl
// Request sequencer: writes loads, walks table entries through the shared
// compare unit one per cycle, and holds the result until the output frees.
// ----------------------------------------------------------------------------
module gct_ctrl
   import gct_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   localparam int AW = $clog2(MAX_ENTRIES)
) (
   input  logic           clock,
   input  logic           reset,
   input  csr_type        csr,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_func,
   input  logic [7:0]     req_slot,
   input  logic [15:0]    req_glyph,
   input  logic [15:0]    req_class_in,
   input  logic           out_free,
   output result_type     res,
   output logic           class_wr_en,
   output logic           range_wr_en,
   output logic [AW-1:0]  wr_addr,
   output logic           rd_en,
   output logic [AW-1:0]  rd_addr,
   output match_mode_type mode,
   output logic [15:0]    glyph_q,
   output logic [15:0]    class_q,
   input  match_type      match
);

   localparam logic [31:0] MAX_W = 32'(MAX_ENTRIES);

   state_type      state_ff, state_in;
   match_mode_type mode_ff, mode_in;
   func_type       func_ff, func_in;
   logic [15:0]    glyph_ff, glyph_in;
   logic [15:0]    class_ff, class_in;
   logic [8:0]     idx_ff, idx_in;
   logic [8:0]     n_ff, n_in;
   logic [15:0]    base_ff, base_in;
   logic           pend_ff, pend_in;
   logic [15:0]    res_class_ff, res_class_in;
   logic           res_found_ff, res_found_in;

   func_type    req_fn;
   logic        accept;
   logic        issue;
   logic        is_load;
   logic [31:0] cnt_w;
   logic [8:0]  n_used;
   logic [16:0] span_end;
   logic        in_span;
   logic [15:0] diff;
   logic [31:0] slot_w;
   logic [31:0] addr_w;

   assign req_fn  = func_type'(req_func);
   assign accept  = req_valid && (state_ff == ST_IDLE);
   assign is_load = (req_fn == FN_LOAD_ARRAY) || (req_fn == FN_LOAD_RANGE);
   assign issue   = (idx_ff < n_ff);

   // entries in use, capped at storage depth
   assign cnt_w    = {23'd0, csr.entry_count};
   assign n_used   = (cnt_w > MAX_W) ? MAX_W[8:0] : csr.entry_count;
   // 17-bit span end, no wrap at the top of the glyph space
   assign span_end = {1'b0, csr.first_glyph} + {8'd0, n_used};
   assign in_span  = (req_glyph >= csr.first_glyph) && ({1'b0, req_glyph} < span_end);
   assign diff     = req_glyph - csr.first_glyph;

   assign slot_w  = {24'd0, req_slot};
   assign addr_w  = {16'd0, base_ff} + {23'd0, idx_ff};
   assign wr_addr = slot_w[AW-1:0];
   assign rd_addr = addr_w[AW-1:0];

   assign mode    = mode_ff;
   assign glyph_q = glyph_ff;
   assign class_q = class_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_load ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((pend_ff && match.hit) || (!issue && !pend_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      class_wr_en   = accept && (req_fn == FN_LOAD_ARRAY) && (slot_w < MAX_W);
      range_wr_en   = accept && (req_fn == FN_LOAD_RANGE) && (slot_w < MAX_W);
      rd_en         = (state_ff == ST_SCAN) && issue;
      res.valid     = (state_ff == ST_DONE) && out_free;
      res.class_out = res_class_ff;
      res.found     = res_found_ff;
   end

   // datapath
   always_comb begin
      mode_in      = mode_ff;
      func_in      = func_ff;
      glyph_in     = glyph_ff;
      class_in     = class_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      pend_in      = pend_ff;
      res_class_in = res_class_ff;
      res_found_in = res_found_ff;
      if (accept) begin
         func_in      = req_fn;
         glyph_in     = req_glyph;
         class_in     = req_class_in;
         idx_in       = 9'd0;
         pend_in      = 1'b0;
         res_class_in = 16'd0;
         res_found_in = 1'b0;
         base_in      = 16'd0;
         n_in         = 9'd0;
         mode_in      = MM_RANGE_HAS;
         if (req_fn == FN_CLASS_OF) begin
            if (csr.table_format == FMT_ARRAY) begin
               // direct index, a single fetch inside the window, none outside
               mode_in = MM_ARRAY_CLASS;
               base_in = diff;
               n_in    = in_span ? 9'd1 : 9'd0;
            end else if (csr.table_format == FMT_RANGE) begin
               mode_in = MM_RANGE_GLYPH;
               n_in    = n_used;
            end
         end else if (req_fn == FN_HAS_CLASS) begin
            if (csr.table_format == FMT_ARRAY) begin
               mode_in = MM_ARRAY_HAS;
               n_in    = n_used;
            end else if (csr.table_format == FMT_RANGE) begin
               mode_in = MM_RANGE_HAS;
               n_in    = n_used;
            end
         end
      end else if (state_ff == ST_SCAN) begin
         if (issue) begin
            idx_in = idx_ff + 9'd1;
         end
         pend_in = issue;
         // first hit in index order wins
         if (pend_ff && match.hit) begin
            res_class_in = (func_ff == FN_CLASS_OF) ? match.cls : 16'd0;
            res_found_in = (func_ff == FN_HAS_CLASS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      func_ff      <= func_in;
      glyph_ff     <= glyph_in;
      class_ff     <= class_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      base_ff      <= base_in;
      res_class_ff <= res_class_in;
      res_found_ff <= res_found_in;
   end

endmodule

FILE: tb/tb_glyph_class_table_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_class_table_lookup_unit
// Self-checking bench for the glyph class table lookup unit. Requests go out
// from a queue through a clocked driver with random gaps. A clocked monitor
// predicts every result at request accept and checks it, field by field,
// against what comes back under random result stalls. Table format, first
// glyph and entry count are set through the CSR port between phases.
// ----------------------------------------------------------------------------
module tb_glyph_class_table_lookup_unit;
   import gct_pkg::*;

   localparam int SLOTS       = DEF_MAX_ENTRIES;
   localparam int RAND_ITEMS  = 1300;
   localparam int QUIET_LIMIT = 4000;   // longest scan reads up to 256 entries, plus stalls
   localparam logic [1:0] FMT_ZERO  = 2'd0;
   localparam logic [1:0] FMT_SPARE = 2'd3;

   typedef struct {
      func_type    func;
      logic [7:0]  slot;
      logic [15:0] glyph;
      logic [15:0] span_first;
      logic [15:0] span_last;
      logic [15:0] class_in;
      bit          drain;      // hold this request until no result is pending
   } glyph_req_type;

   typedef struct {
      logic [15:0] class_out;
      logic        found;
   } glyph_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_func = 2'd0;
   logic [7:0]            req_slot = 8'd0;
   logic [15:0]           req_glyph = 16'd0;
   logic [15:0]           req_span_first = 16'd0;
   logic [15:0]           req_span_last = 16'd0;
   logic [15:0]           req_class_in = 16'd0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [15:0]           rsp_class_out;
   logic                  rsp_found;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = 32'd0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   glyph_class_table_lookup_unit dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_slot, .req_glyph,
      .req_span_first, .req_span_last, .req_class_in,
      .rsp_valid, .rsp_stall, .rsp_class_out, .rsp_found,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to go out, and results owed by the block, oldest first
   glyph_req_type req_pending[$];
   glyph_rsp_type rsp_expect[$];

   int errors = 0;
   int quiet = 0;       // cycles with no request and no result accepted
   int queued = 0;

   // Handshake bookkeeping shared by the posedge monitor and negedge drivers
   bit req_fired = 1'b0;
   int gap_left = 0;
   int rsp_wait = 0;
   int snd_mode = 0, snd_run = 0;
   int rcv_mode = 0, rcv_run = 0;

   // Predictor copy of the block: CSRs set by csr_write, both tables updated at accept
   logic [1:0]  mirror_format = FMT_ZERO;
   logic [15:0] mirror_first = 16'd0;
   logic [8:0]  mirror_count = 9'd0;
   logic [15:0] mirror_cls  [SLOTS];
   logic [15:0] mirror_lo   [SLOTS];
   logic [15:0] mirror_hi   [SLOTS];
   logic [15:0] mirror_rcls [SLOTS];

   // Generator view of what has been queued, used to aim queries and to
   // keep queries off entries that were never loaded
   logic [1:0]  plan_fmt = FMT_ZERO;
   logic [15:0] plan_first = 16'd0;
   int          plan_n = 0;
   logic [15:0] plan_cls  [SLOTS];
   logic [15:0] plan_lo   [SLOTS];
   logic [15:0] plan_hi   [SLOTS];
   logic [15:0] plan_rcls [SLOTS];
   bit          plan_arr_ok [SLOTS];
   bit          plan_rec_ok [SLOTS];

   // Idle draw per request: runs of no idling, uniformly drawn gaps, or rare gaps
   function automatic int idle_cycles(inout int mode, inout int run);
      if (run == 0) begin
         mode = $urandom_range(0, 2);
         run  = $urandom_range(4, 40);
      end
      run--;
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 14);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      endcase
   endfunction

   // Class of a glyph: format 1 window end kept in 17 bits so it never wraps,
   // format 2 takes the lowest-index record whose span holds the glyph
   function automatic logic [15:0] predict_class(input logic [15:0] g);
      int          used;
      logic [16:0] win_end;
      used = (mirror_count > SLOTS) ? SLOTS : mirror_count;
      if (mirror_format == FMT_ARRAY) begin
         win_end = {1'b0, mirror_first} + 17'(used);
         if (g >= mirror_first && {1'b0, g} < win_end)
            return mirror_cls[8'(g - mirror_first)];
         return 16'd0;
      end
      if (mirror_format == FMT_RANGE) begin
         for (int i = 0; i < used; i++)
            if (g >= mirror_lo[i] && g <= mirror_hi[i])
               return mirror_rcls[i];
      end
      return 16'd0;
   endfunction

   function automatic logic predict_found(input logic [15:0] c);
      int used;
      used = (mirror_count > SLOTS) ? SLOTS : mirror_count;
      for (int i = 0; i < used; i++) begin
         if (mirror_format == FMT_ARRAY && mirror_cls[i] == c)
            return 1'b1;
         if (mirror_format == FMT_RANGE && mirror_rcls[i] == c)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: result check, request capture and prediction, watchdog.
   // Everything here samples values that settled at the previous negedge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      glyph_rsp_type want;
      bit            moved;
      moved = 1'b0;
      if (reset) begin
         quiet = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            rsp_wait = idle_cycles(rcv_mode, rcv_run);
            if (rsp_expect.size() == 0) begin
               errors++;
               $display("%0t: result with none pending: class_out %h found %b",
                        $time, rsp_class_out, rsp_found);
            end else begin
               want = rsp_expect.pop_front();
               if (rsp_class_out !== want.class_out) begin
                  errors++;
                  $display("%0t: class_out expected %h actual %h",
                           $time, want.class_out, rsp_class_out);
               end
               if (rsp_found !== want.found) begin
                  errors++;
                  $display("%0t: found expected %b actual %b",
                           $time, want.found, rsp_found);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            req_fired = 1'b1;
            gap_left = idle_cycles(snd_mode, snd_run);
            want.class_out = 16'd0;
            want.found = 1'b0;
            // loads land in the tables whatever the format is
            case (func_type'(req_func))
               FN_LOAD_ARRAY: mirror_cls[req_slot] = req_class_in;
               FN_LOAD_RANGE: begin
                  mirror_lo[req_slot]   = req_span_first;
                  mirror_hi[req_slot]   = req_span_last;
                  mirror_rcls[req_slot] = req_class_in;
               end
               FN_CLASS_OF: want.class_out = predict_class(req_glyph);
               default: want.found = predict_found(req_class_in);
            endcase
            rsp_expect.push_back(want);
         end
         if (moved) begin
            quiet = 0;
         end else if (++quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: a presented request holds until accepted, then the
   // drawn gap runs out before the next one goes up.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      glyph_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         req_fired = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_pending.size() > 0 &&
                      !(req_pending[0].drain && rsp_expect.size() > 0)) begin
            nxt = req_pending.pop_front();
            req_func       <= nxt.func;
            req_slot       <= nxt.slot;
            req_glyph      <= nxt.glyph;
            req_span_first <= nxt.span_first;
            req_span_last  <= nxt.span_last;
            req_class_in   <= nxt.class_in;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: after each accepted result, stall for the drawn count
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_FORMAT:      mirror_format = val[1:0];
         REG_FIRST_GLYPH: mirror_first  = val[15:0];
         REG_ENTRY_COUNT: mirror_count  = val[8:0];
         default: ;
      endcase
   endtask

   // Block is idle once nothing is queued, presented or owed
   task automatic wait_idle();
      while (req_pending.size() > 0 || rsp_expect.size() > 0 || req_valid)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_table(input logic [1:0] fmt, input logic [15:0] first,
                            input logic [8:0] count);
      wait_idle();
      csr_write(REG_FORMAT, 32'(fmt));
      csr_write(REG_FIRST_GLYPH, 32'(first));
      csr_write(REG_ENTRY_COUNT, 32'(count));
      plan_fmt   = fmt;
      plan_first = first;
      plan_n     = (count > SLOTS) ? SLOTS : count;
   endtask

   function automatic logic [15:0] pick_class();
      case ($urandom_range(0, 9))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2, 3: return 16'($urandom);
         default: return 16'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic glyph_req_type noise_req(input func_type f);
      glyph_req_type r;
      r.func       = f;
      r.slot       = 8'($urandom);
      r.glyph      = 16'($urandom);
      r.span_first = 16'($urandom);
      r.span_last  = 16'($urandom);
      r.class_in   = 16'($urandom);
      r.drain      = ($urandom_range(0, 39) == 0);
      return r;
   endfunction

   task automatic queue_req(input glyph_req_type r);
      case (r.func)
         FN_LOAD_ARRAY: begin
            plan_cls[r.slot]    = r.class_in;
            plan_arr_ok[r.slot] = 1'b1;
         end
         FN_LOAD_RANGE: begin
            plan_lo[r.slot]     = r.span_first;
            plan_hi[r.slot]     = r.span_last;
            plan_rcls[r.slot]   = r.class_in;
            plan_rec_ok[r.slot] = 1'b1;
         end
         default: ;
      endcase
      req_pending.push_back(r);
      queued++;
   endtask

   task automatic put(input func_type f, input int slot, input int glyph,
                      input int sf, input int sl, input int cls, input bit drain);
      glyph_req_type r;
      r = noise_req(f);
      r.slot       = 8'(slot);
      r.glyph      = 16'(glyph);
      r.span_first = 16'(sf);
      r.span_last  = 16'(sl);
      r.class_in   = 16'(cls);
      r.drain      = drain;
      queue_req(r);
   endtask

   // Load every entry in use that was never written; small tables are often
   // rewritten too. Ranges go in sorted, one per bin, unless the phase is a
   // deliberately untidy one.
   task automatic fill_table();
      glyph_req_type r;
      bit            tidy, rewrite;
      int            step, a, b;
      tidy    = ($urandom_range(0, 4) != 0);
      rewrite = (plan_n <= 32) && ($urandom_range(0, 3) != 0);
      step    = (plan_n > 0) ? 65536 / plan_n : 0;
      for (int i = 0; i < plan_n; i++) begin
         if (plan_fmt == FMT_ARRAY && (!plan_arr_ok[i] || rewrite)) begin
            r = noise_req(FN_LOAD_ARRAY);
            r.slot = 8'(i);
            r.class_in = pick_class();
            queue_req(r);
         end else if (plan_fmt == FMT_RANGE && (!plan_rec_ok[i] || rewrite)) begin
            r = noise_req(FN_LOAD_RANGE);
            r.slot = 8'(i);
            r.class_in = pick_class();
            if (tidy) begin
               a = $urandom_range(0, step - 1);
               b = $urandom_range(0, step - 1);
               r.span_first = 16'(i * step + ((a < b) ? a : b));
               r.span_last  = 16'(i * step + ((a < b) ? b : a));
            end
            queue_req(r);
         end
      end
   endtask

   // One random request aimed at the active table: hits, edges, misses,
   // class probes and reloads, with some loads into the idle table
   task automatic queue_op();
      glyph_req_type r;
      int            pick, k;
      pick = $urandom_range(0, 99);
      k = (plan_n > 0) ? $urandom_range(0, plan_n - 1) : 0;
      if (pick < 35) begin
         r = noise_req(FN_CLASS_OF);
         case ($urandom_range(0, 4))
            0, 1, 2: begin
               if (plan_fmt == FMT_ARRAY)
                  r.glyph = 16'(plan_first + k);
               else if (plan_fmt == FMT_RANGE && plan_n > 0)
                  r.glyph = 16'(plan_lo[k] + $urandom_range(0,
                            (plan_hi[k] >= plan_lo[k]) ? plan_hi[k] - plan_lo[k] : 0));
            end
            3: begin
               if (plan_fmt == FMT_ARRAY)
                  r.glyph = $urandom_range(0, 1) ? 16'(plan_first - 1)
                                                 : 16'(plan_first + plan_n);
               else if (plan_fmt == FMT_RANGE && plan_n > 0)
                  r.glyph = $urandom_range(0, 1) ? 16'(plan_lo[k] - 1)
                                                 : 16'(plan_hi[k] + 1);
            end
            default: ;
         endcase
      end else if (pick < 60) begin
         r = noise_req(FN_HAS_CLASS);
         if (plan_n > 0 && $urandom_range(0, 1))
            r.class_in = (plan_fmt == FMT_RANGE) ? plan_rcls[k] : plan_cls[k];
         else if ($urandom_range(0, 1))
            r.class_in = 16'($urandom_range(0, 15));
      end else if (pick < 90) begin
         if (plan_fmt == FMT_RANGE) begin
            r = noise_req(FN_LOAD_RANGE);
            // mostly keep the span so the record set stays sorted
            if (plan_n > 0 && $urandom_range(0, 3) != 0) begin
               r.slot       = 8'(k);
               r.span_first = plan_lo[k];
               r.span_last  = plan_hi[k];
            end
         end else begin
            r = noise_req(FN_LOAD_ARRAY);
         end
         r.class_in = pick_class();
      end else begin
         r = noise_req($urandom_range(0, 1) ? FN_LOAD_ARRAY : FN_LOAD_RANGE);
      end
      queue_req(r);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int         phase, n_ops, r;
      logic [1:0] fmt;
      logic [15:0] first;
      logic [8:0] count;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Range records: overlap resolved by lowest index, an inverted span
      // that holds no glyph but still carries its class, top-of-space span
      set_table(FMT_RANGE, 16'h0000, 9'd4);
      put(FN_LOAD_RANGE, 0, 0, 'h0010, 'h0020, 'h0001, 1'b0);
      put(FN_LOAD_RANGE, 1, 0, 'h0018, 'h0030, 'hFFFF, 1'b0);
      put(FN_LOAD_RANGE, 2, 0, 'h0100, 'h00FF, 'h0005, 1'b0);
      put(FN_LOAD_RANGE, 3, 0, 'hFFF0, 'hFFFF, 'h8000, 1'b0);
      put(FN_LOAD_ARRAY, 255, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1'b0);
      put(FN_CLASS_OF, 0, 'h0018, 0, 0, 0, 1'b1);
      put(FN_CLASS_OF, 0, 'h0025, 0, 0, 0, 1'b0);
      put(FN_CLASS_OF, 0, 'h0100, 0, 0, 0, 1'b0);
      put(FN_CLASS_OF, 0, 'hFFFF, 0, 0, 0, 1'b0);
      put(FN_CLASS_OF, 0, 'h0000, 0, 0, 0, 1'b0);
      put(FN_HAS_CLASS, 0, 0, 0, 0, 'hFFFF, 1'b0);
      put(FN_HAS_CLASS, 0, 0, 0, 0, 'h0005, 1'b0);
      put(FN_HAS_CLASS, 0, 0, 0, 0, 'h1234, 1'b0);

      // Dense array at the top of glyph space: the window end must not wrap
      set_table(FMT_ARRAY, 16'hFFFE, 9'd2);
      put(FN_LOAD_ARRAY, 0, 0, 0, 0, 'h00AA, 1'b0);
      put(FN_LOAD_ARRAY, 1, 0, 0, 0, 'h5555, 1'b0);
      put(FN_CLASS_OF, 0, 'hFFFE, 0, 0, 0, 1'b0);
      put(FN_CLASS_OF, 0, 'hFFFF, 0, 0, 0, 1'b0);
      put(FN_CLASS_OF, 0, 'h0000, 0, 0, 0, 1'b0);
      put(FN_CLASS_OF, 0, 'hFFFD, 0, 0, 0, 1'b0);
      put(FN_HAS_CLASS, 0, 0, 0, 0, 'h5555, 1'b0);

      // Formats 0 and 3 answer zero no matter what is loaded
      set_table(FMT_ZERO, 16'hFFFE, 9'd2);
      put(FN_CLASS_OF, 0, 'hFFFE, 0, 0, 0, 1'b0);
      put(FN_HAS_CLASS, 0, 0, 0, 0, 'h00AA, 1'b0);
      set_table(FMT_SPARE, 16'hFFFE, 9'd2);
      put(FN_CLASS_OF, 0, 'hFFFF, 0, 0, 0, 1'b0);
      put(FN_HAS_CLASS, 0, 0, 0, 0, 'h5555, 1'b0);

      // Random phases; the first few pin the CSR extremes
      queued = 0;
      phase = 0;
      while (queued < RAND_ITEMS) begin
         case (phase)
            0: set_table(FMT_RANGE, 16'h0000, 9'd0);
            1: set_table(FMT_ARRAY, 16'hFF80, 9'd511);
            2: set_table(FMT_SPARE, 16'hFFFF, 9'd256);
            3: set_table(FMT_RANGE, 16'hFFFF, 9'd256);
            default: begin
               r = $urandom_range(0, 9);
               fmt = (r < 4) ? FMT_ARRAY : (r < 8) ? FMT_RANGE :
                     (r == 8) ? FMT_ZERO : FMT_SPARE;
               case ($urandom_range(0, 5))
                  0: first = 16'h0000;
                  1: first = 16'hFFFF;
                  2: first = 16'(16'hFFFF - $urandom_range(0, 300));
                  default: first = 16'($urandom);
               endcase
               case ($urandom_range(0, 19))
                  0: count = 9'd0;
                  1: count = 9'($urandom_range(256, 511));
                  default: count = 9'($urandom_range(1, 24));
               endcase
               set_table(fmt, first, count);
            end
         endcase
         phase++;
         fill_table();
         n_ops = $urandom_range(20, 60);
         repeat (n_ops) queue_op();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
